@@ rtl/core/shaded_palette_recolor_macros.svh @@
// assertion macros for the palette recolor core
`ifndef SHADED_PALETTE_RECOLOR_MACROS_SVH
`define SHADED_PALETTE_RECOLOR_MACROS_SVH

`ifndef ASSERT_OFF
`define SPR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spr assertion failed");
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spr assertion failed");
`else
`define SPR_ASSERT_SAME(lbl, ante, cons)
`define SPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/spr_pkg.sv @@
package spr_pkg;

	localparam int PALETTE_DEPTH_DEF = 32;
	localparam int SUM_W  = 10;
	localparam int PROD_W = 18;
	localparam int CNT_W  = 6;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// fields of a pixel after the input stage
	typedef struct packed {
		logic [2:0][7:0] orig_rgb;
		logic [7:0]      orig_alpha;
		logic [2:0][7:0] flat_rgb;
		logic [SUM_W-1:0] lit_sum;
		logic [SUM_W-1:0] flat_sum;
		logic             pass;
	} spr_pix_t;

	typedef struct packed {
		logic [2:0][7:0] rgb;
		logic [7:0]      alpha;
		logic            recolored;
		logic            use_quot;
	} spr_side_t;

	typedef struct packed {
		logic [2:0][PROD_W-1:0] rem;
		logic [2:0][7:0]        quo;
		logic [SUM_W-1:0]       divisor;
		spr_side_t              side;
	} spr_div_t;

endpackage

@@ rtl/core/spr_front.sv @@
module spr_front #(
	parameter int PALETTE_DEPTH = spr_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic                        action,
	input  logic [4:0]                  entry_index,
	input  logic [7:0]                  orig_red,
	input  logic [7:0]                  orig_green,
	input  logic [7:0]                  orig_blue,
	input  logic [7:0]                  orig_alpha,
	input  logic [7:0]                  flat_red,
	input  logic [7:0]                  flat_green,
	input  logic [7:0]                  flat_blue,
	input  logic [7:0]                  flat_alpha,
	input  logic [spr_pkg::CNT_W-1:0]   palette_count,
	output logic                        valid_s1,
	output spr_pkg::spr_pix_t           pix_s1,
	output logic [23:0]                 pal_s1
);

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [23:0]      palette [PALETTE_DEPTH];
	logic             take;
	logic             wr_en;
	logic [8:0]       entry_wide;
	logic [7:0]       mat_id;
	spr_pkg::spr_pix_t pix_d;

	assign take       = in_valid && en;
	assign entry_wide = {4'b0, entry_index};
	assign wr_en      = take && (action == spr_pkg::ACT_LOAD) &&
		(entry_wide < 9'(PALETTE_DEPTH));
	// material id is stored inverted in the unlit alpha
	assign mat_id     = ~flat_alpha;

	always_comb begin
		pix_d.orig_rgb   = {orig_red, orig_green, orig_blue};
		pix_d.orig_alpha = orig_alpha;
		pix_d.flat_rgb   = {flat_red, flat_green, flat_blue};
		pix_d.lit_sum    = 10'(orig_red) + 10'(orig_green) + 10'(orig_blue);
		pix_d.flat_sum   = 10'(flat_red) + 10'(flat_green) + 10'(flat_blue);
		pix_d.pass       = (orig_alpha == 8'd0) || (mat_id >= {2'b0, palette_count}) ||
			({1'b0, mat_id} >= 9'(PALETTE_DEPTH));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette[entry_wide[IDX_W-1:0]] <= {orig_red, orig_green, orig_blue};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pal_s1 <= palette[mat_id[IDX_W-1:0]];
			pix_s1 <= pix_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && (action == spr_pkg::ACT_PIXEL);
		end
	end

endmodule

@@ rtl/core/spr_shade.sv @@
module spr_shade (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s1,
	input  spr_pkg::spr_pix_t pix_s1,
	input  logic [23:0]       pal_s1,
	output logic              valid_s2,
	output spr_pkg::spr_div_t div_s2
);

	logic [2:0][7:0]  pal;
	logic signed [9:0] delta_sum;
	spr_pkg::spr_div_t div_d;

	assign pal = pal_s1;

	always_comb begin
		div_d         = '0;
		delta_sum     = '0;
		div_d.divisor = pix_s1.flat_sum;
		div_d.side.alpha = pix_s1.orig_alpha;
		for (int c = 0; c < 3; c++) begin
			div_d.rem[c] = spr_pkg::PROD_W'({10'b0, pal[c]} * {8'b0, pix_s1.lit_sum});
		end
		if (pix_s1.pass) begin
			div_d.side.rgb = pix_s1.orig_rgb;
		end else if (pix_s1.flat_sum == '0) begin
			div_d.side.rgb       = pal;
			div_d.side.recolored = 1'b1;
		end else if (pix_s1.lit_sum >= pix_s1.flat_sum) begin
			div_d.side.recolored = 1'b1;
			for (int c = 0; c < 3; c++) begin
				delta_sum = $signed({2'b0, pal[c]}) + $signed({2'b0, pix_s1.orig_rgb[c]}) -
					$signed({2'b0, pix_s1.flat_rgb[c]});
				if (delta_sum < 0) begin
					div_d.side.rgb[c] = 8'd0;
				end else if (delta_sum > 10'sd255) begin
					div_d.side.rgb[c] = 8'd255;
				end else begin
					div_d.side.rgb[c] = delta_sum[7:0];
				end
			end
		end else begin
			div_d.side.recolored = 1'b1;
			div_d.side.use_quot  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2 <= div_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

endmodule

@@ rtl/core/spr_div_stage.sv @@
// two restoring division steps per stage, three channels side by side
module spr_div_stage #(
	parameter int HI_BIT = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  spr_pkg::spr_div_t din,
	output logic              vout,
	output spr_pkg::spr_div_t dout
);

	logic [spr_pkg::PROD_W-1:0] trial;
	spr_pkg::spr_div_t          nxt;

	always_comb begin
		nxt   = din;
		trial = '0;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 2; k++) begin
				trial = spr_pkg::PROD_W'(din.divisor) << (HI_BIT - k);
				if (nxt.rem[c] >= trial) begin
					nxt.rem[c]             = nxt.rem[c] - trial;
					nxt.quo[c][HI_BIT - k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

endmodule

@@ rtl/core/shaded_palette_recolor.sv @@
// Palette recolor with shading. Load items (action 0) write one RGB palette entry and give
// no result; pixel items (action 1) give one result each, in order. One item is taken per
// clock while in_ready is high. A pixel result passes through six register stages: the
// input stage with the registered palette read, the shading and multiply stage, and four
// divider stages that each settle two quotient bits of lit_sum * color / flat_sum. Stages
// advance independently, so bubbles are squeezed out while the output is stalled.
// palette_count is written through cfg_wr_en/cfg_wr_data and resets to zero.
`include "shaded_palette_recolor_macros.svh"

module shaded_palette_recolor #(
	parameter int PALETTE_DEPTH = spr_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [spr_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [4:0]                entry_index,
	input  logic [7:0]                orig_red,
	input  logic [7:0]                orig_green,
	input  logic [7:0]                orig_blue,
	input  logic [7:0]                orig_alpha,
	input  logic [7:0]                flat_red,
	input  logic [7:0]                flat_green,
	input  logic [7:0]                flat_blue,
	input  logic [7:0]                flat_alpha,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_red,
	output logic [7:0]                out_green,
	output logic [7:0]                out_blue,
	output logic [7:0]                out_alpha,
	output logic                      recolored
);

	logic [spr_pkg::CNT_W-1:0] count_q;
	logic                      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic                      en1, en2, en3, en4, en5, en6;
	spr_pkg::spr_pix_t         pix_s1;
	logic [23:0]               pal_s1;
	spr_pkg::spr_div_t         div_s2, div_s3, div_s4, div_s5, div_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// a stage loads when it is empty or its content moves on
	assign en6      = !valid_s6 || out_ready;
	assign en5      = !valid_s5 || en6;
	assign en4      = !valid_s4 || en5;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	spr_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en1),
		.in_valid     (in_valid),
		.action       (action),
		.entry_index  (entry_index),
		.orig_red     (orig_red),
		.orig_green   (orig_green),
		.orig_blue    (orig_blue),
		.orig_alpha   (orig_alpha),
		.flat_red     (flat_red),
		.flat_green   (flat_green),
		.flat_blue    (flat_blue),
		.flat_alpha   (flat_alpha),
		.palette_count(count_q),
		.valid_s1     (valid_s1),
		.pix_s1       (pix_s1),
		.pal_s1       (pal_s1)
	);

	spr_shade u_shade (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en2),
		.valid_s1(valid_s1),
		.pix_s1  (pix_s1),
		.pal_s1  (pal_s1),
		.valid_s2(valid_s2),
		.div_s2  (div_s2)
	);

	spr_div_stage #(.HI_BIT(7)) u_div3 (
		.clk(clk), .arst_n(arst_n), .en(en3),
		.vin(valid_s2), .din(div_s2), .vout(valid_s3), .dout(div_s3)
	);

	spr_div_stage #(.HI_BIT(5)) u_div4 (
		.clk(clk), .arst_n(arst_n), .en(en4),
		.vin(valid_s3), .din(div_s3), .vout(valid_s4), .dout(div_s4)
	);

	spr_div_stage #(.HI_BIT(3)) u_div5 (
		.clk(clk), .arst_n(arst_n), .en(en5),
		.vin(valid_s4), .din(div_s4), .vout(valid_s5), .dout(div_s5)
	);

	spr_div_stage #(.HI_BIT(1)) u_div6 (
		.clk(clk), .arst_n(arst_n), .en(en6),
		.vin(valid_s5), .din(div_s5), .vout(valid_s6), .dout(div_s6)
	);

	assign out_valid = valid_s6;
	assign out_red   = div_s6.side.use_quot ? div_s6.quo[2] : div_s6.side.rgb[2];
	assign out_green = div_s6.side.use_quot ? div_s6.quo[1] : div_s6.side.rgb[1];
	assign out_blue  = div_s6.side.use_quot ? div_s6.quo[0] : div_s6.side.rgb[0];
	assign out_alpha = div_s6.side.alpha;
	assign recolored = div_s6.side.recolored;

	`SPR_ASSERT_SAME(a_stall_only_when_full, !in_ready, valid_s1 && out_valid && !out_ready)
	`SPR_ASSERT_NEXT(a_pixel_enters, in_valid && in_ready && (action == spr_pkg::ACT_PIXEL), valid_s1)
	`SPR_ASSERT_NEXT(a_load_no_entry, in_valid && in_ready && (action == spr_pkg::ACT_LOAD), !valid_s1)
	`SPR_ASSERT_SAME(a_quot_is_recolor, out_valid && div_s6.side.use_quot, recolored)

endmodule

@@ sim/testbench.sv @@
module testbench;

	localparam int DEPTH       = spr_pkg::PALETTE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 70;

	typedef struct packed {
		logic       act;
		logic [4:0] idx;
		logic [7:0] lit_r;
		logic [7:0] lit_g;
		logic [7:0] lit_b;
		logic [7:0] lit_a;
		logic [7:0] flat_r;
		logic [7:0] flat_g;
		logic [7:0] flat_b;
		logic [7:0] flat_a;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       recolored;
	} pixel_res_t;

	typedef enum logic [1:0] {ROW_CONFIG, ROW_PREDICT, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [5:0] count;
		pixel_req_t req;
		pixel_res_t res;
	} stim_row_t;

	localparam stim_row_t DIRECTED [18] = '{
		// nothing recolors right after reset since the palette count is zero
		'{ROW_TYPED, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd90, 8'd90, 8'd90, 8'd255},
			'{8'd10, 8'd20, 8'd30, 8'd40, 1'b0}},
		'{ROW_CONFIG, 6'd32, '0, '0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_LOAD, 5'd0, 8'd200, 8'd100, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, '0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_LOAD, 5'd31, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255}, '0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_LOAD, 5'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, '0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_LOAD, 5'd1, 8'd128, 8'd64, 8'd255, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9}, '0},
		// background
		'{ROW_TYPED, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd4, 8'd5, 8'd6, 8'd255},
			'{8'd1, 8'd2, 8'd3, 8'd0, 1'b0}},
		// black unlit pixel gives the plain palette color
		'{ROW_TYPED, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd9, 8'd9, 8'd9, 8'd128, 8'd0, 8'd0, 8'd0, 8'd255},
			'{8'd200, 8'd100, 8'd50, 8'd128, 1'b1}},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd31, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd1,
			8'd224}, '0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd100, 8'd0, 8'd0, 8'd7, 8'd0, 8'd50, 8'd40, 8'd250},
			'0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd10, 8'd10, 8'd10, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd254}, '0},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd254}, '0},
		// material 32 and material 255 lie beyond the palette
		'{ROW_TYPED, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd11, 8'd22, 8'd33, 8'd44, 8'd5, 8'd5, 8'd5, 8'd223},
			'{8'd11, 8'd22, 8'd33, 8'd44, 1'b0}},
		'{ROW_TYPED, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd31, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0},
			'{8'd255, 8'd0, 8'd255, 8'd255, 1'b0}},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255}, '0},
		'{ROW_CONFIG, 6'd1, '0, '0},
		'{ROW_TYPED, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd7, 8'd8, 8'd9, 8'd10, 8'd1, 8'd1, 8'd1, 8'd254},
			'{8'd7, 8'd8, 8'd9, 8'd10, 1'b0}},
		'{ROW_PREDICT, 6'd0,
			'{spr_pkg::ACT_PIXEL, 5'd0, 8'd50, 8'd60, 8'd70, 8'd200, 8'd100, 8'd100, 8'd100,
			8'd255}, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [spr_pkg::CNT_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [4:0] entry_index = '0;
	logic [7:0] orig_red = '0;
	logic [7:0] orig_green = '0;
	logic [7:0] orig_blue = '0;
	logic [7:0] orig_alpha = '0;
	logic [7:0] flat_red = '0;
	logic [7:0] flat_green = '0;
	logic [7:0] flat_blue = '0;
	logic [7:0] flat_alpha = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic recolored;

	// predictor state
	logic [23:0] swatch [DEPTH];
	bit swatch_loaded [DEPTH];
	logic [5:0] material_limit = '0;

	pixel_res_t pending_pixels [$];
	int mismatch_count = 0;
	int pixels_seen = 0;
	int cycle_count = 0;
	bit burst_phase = 1'b0;

	shaded_palette_recolor uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.entry_index(entry_index),
		.orig_red(orig_red),
		.orig_green(orig_green),
		.orig_blue(orig_blue),
		.orig_alpha(orig_alpha),
		.flat_red(flat_red),
		.flat_green(flat_green),
		.flat_blue(flat_blue),
		.flat_alpha(flat_alpha),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha),
		.recolored(recolored)
	);

	always #1 clk = ~clk;

	function automatic pixel_res_t recolor_pixel(input pixel_req_t p);
		pixel_res_t r;
		int material, lit_sum, flat_sum, base, chan, c;
		int lit [3];
		int flat [3];
		logic [7:0] rgb [3];
		lit = '{int'(p.lit_r), int'(p.lit_g), int'(p.lit_b)};
		flat = '{int'(p.flat_r), int'(p.flat_g), int'(p.flat_b)};
		r.alpha = p.lit_a;
		material = 255 - int'(p.flat_a);
		if (p.lit_a == 8'd0 || material >= int'(material_limit) || material >= DEPTH) begin
			r.red = p.lit_r;
			r.green = p.lit_g;
			r.blue = p.lit_b;
			r.recolored = 1'b0;
			return r;
		end
		lit_sum = lit[0] + lit[1] + lit[2];
		flat_sum = flat[0] + flat[1] + flat[2];
		for (c = 0; c < 3; c++) begin
			base = int'(swatch[material][23 - 8 * c -: 8]);
			if (flat_sum == 0)
				chan = base;
			else if (lit_sum >= flat_sum)
				chan = base + lit[c] - flat[c];
			else
				chan = base * lit_sum / flat_sum;
			if (chan < 0)
				chan = 0;
			if (chan > 255)
				chan = 255;
			rgb[c] = chan[7:0];
		end
		r.red = rgb[0];
		r.green = rgb[1];
		r.blue = rgb[2];
		r.recolored = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] near_value(input logic [7:0] v);
		int t;
		t = int'(v) + int'($urandom_range(16)) - 8;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return t[7:0];
	endfunction

	function automatic pixel_req_t make_random_item();
		pixel_req_t it;
		int pick, material;
		pick = $urandom_range(99);
		it.act = spr_pkg::ACT_PIXEL;
		it.idx = 5'($urandom);
		it.lit_r = 8'($urandom);
		it.lit_g = 8'($urandom);
		it.lit_b = 8'($urandom);
		it.lit_a = 8'($urandom_range(255, 1));
		it.flat_r = 8'($urandom);
		it.flat_g = 8'($urandom);
		it.flat_b = 8'($urandom);
		it.flat_a = 8'($urandom);
		if (pick < 12) begin
			it.act = spr_pkg::ACT_LOAD;
		end else if (pick < 20) begin
			it.lit_a = 8'd0;
		end else if (pick >= 30 && material_limit != 0) begin
			// well-formed pixel on a material in use
			it.flat_a = 8'(255 - $urandom_range(int'(material_limit) - 1));
			pick = $urandom_range(9);
			if (pick == 0) begin
				it.flat_r = 8'd0;
				it.flat_g = 8'd0;
				it.flat_b = 8'd0;
			end else if (pick < 4) begin
				it.flat_r = near_value(it.lit_r);
				it.flat_g = near_value(it.lit_g);
				it.flat_b = near_value(it.lit_b);
			end
		end
		// never look up an entry that has not been loaded
		material = 255 - int'(it.flat_a);
		if (it.act == spr_pkg::ACT_PIXEL && it.lit_a != 8'd0 &&
				material < int'(material_limit) && material < DEPTH &&
				!swatch_loaded[material]) begin
			it.act = spr_pkg::ACT_LOAD;
			it.idx = 5'(material);
		end
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_phase)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic drive_payload(input pixel_req_t it);
		action <= it.act;
		entry_index <= it.idx;
		orig_red <= it.lit_r;
		orig_green <= it.lit_g;
		orig_blue <= it.lit_b;
		orig_alpha <= it.lit_a;
		flat_red <= it.flat_r;
		flat_green <= it.flat_g;
		flat_blue <= it.flat_b;
		flat_alpha <= it.flat_a;
	endtask

	task automatic queue_result(input pixel_res_t r);
		pending_pixels.insert(pending_pixels.size(), r);
	endtask

	task automatic send_item(input pixel_req_t it, input bit typed, input pixel_res_t typed_res);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			drive_payload(make_random_item());
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		drive_payload(it);
		do @(posedge clk); while (in_ready !== 1'b1);
		if (it.act == spr_pkg::ACT_LOAD) begin
			swatch[it.idx] = {it.lit_r, it.lit_g, it.lit_b};
			swatch_loaded[it.idx] = 1'b1;
		end else begin
			queue_result(typed ? typed_res : recolor_pixel(it));
		end
	endtask

	// loads give no result, so allow the pipeline to drain past the last pixel
	task automatic settle();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic program_count(input logic [5:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		material_limit = value;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %0d %0d %0d %0d %0b",
					$time, out_red, out_green, out_blue, out_alpha, recolored);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_red", want.red, out_red);
				check_field("out_green", want.green, out_green);
				check_field("out_blue", want.blue, out_blue);
				check_field("out_alpha", want.alpha, out_alpha);
				check_field("recolored", {7'd0, want.recolored}, {7'd0, recolored});
			end
		end
	end

	// receiver side
	initial begin
		int mode, seg;
		bit held_long;
		held_long = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_long && pixels_seen >= 80 && in_valid === 1'b1) begin
				// long stall so the pipeline backs up into the input
				held_long = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			mode = $urandom_range(3);
			seg = $urandom_range(80, 20);
			repeat (seg) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(99) < 70);
					2: out_ready <= ($urandom_range(99) < 30);
					default: begin
						if ($urandom_range(49) == 0) begin
							out_ready <= 1'b0;
							repeat ($urandom_range(60, 20)) @(posedge clk);
						end
						out_ready <= 1'b1;
					end
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int ph;
		logic [5:0] phase_counts [6];
		phase_counts = '{6'd32, 6'd0, 6'd13, 6'd32, 6'd1, 6'($urandom_range(32))};
		foreach (swatch_loaded[i])
			swatch_loaded[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CONFIG) begin
				in_valid <= 1'b0;
				settle();
				program_count(DIRECTED[i].count);
			end else begin
				send_item(DIRECTED[i].req, DIRECTED[i].kind == ROW_TYPED, DIRECTED[i].res);
			end
		end

		for (ph = 0; ph < 6; ph++) begin
			in_valid <= 1'b0;
			settle();
			program_count(phase_counts[ph]);
			burst_phase = (ph == 1) || ($urandom_range(3) == 0);
			repeat (PHASE_ITEMS) send_item(make_random_item(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		settle();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/spr_pkg.sv
rtl/core/spr_front.sv
rtl/core/spr_shade.sv
rtl/core/spr_div_stage.sv
rtl/core/shaded_palette_recolor.sv
sim/testbench.sv
